FILE: sv/twic_pkg.sv
// Shared types and constants for the trie word insert and count core.
`default_nettype none
package twic_pkg;

  localparam int TWIC_NODES      = 1024;
  localparam int TWIC_ALPHABET   = 26;
  localparam int TWIC_COUNT_BITS = 32;

  localparam int LETTER_W = 5;
  localparam int OUT_CNT_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

endpackage
`default_nettype wire

FILE: sv/twic_ram.sv
// Single-port synchronous RAM with registered read data.
`default_nettype none
module twic_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/twic_ctrl.sv
// Walk sequencer: clear pass, link lookup and allocation, count updates, result register.
`default_nettype none
module twic_ctrl
  import twic_pkg::*;
#(
  parameter int NODES      = TWIC_NODES,
  parameter int ALPHABET   = TWIC_ALPHABET,
  parameter int COUNT_BITS = TWIC_COUNT_BITS,
  localparam int NW = $clog2(NODES),
  localparam int FW = $clog2(NODES + 1),
  localparam int LINK_DEPTH = NODES * ALPHABET,
  localparam int LW = $clog2(LINK_DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_op,
  input  wire logic [LETTER_W-1:0]     in_letter,
  input  wire logic                    in_last,
  input  wire logic                    in_empty_word,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_status,
  output logic [OUT_CNT_W-1:0]         out_word_count,
  output logic [OUT_CNT_W-1:0]         out_prefix_count,
  output logic                         link_re,
  output logic                         link_we,
  output logic [LW-1:0]                link_addr,
  output logic [NW-1:0]                link_wdata,
  input  wire logic [NW-1:0]           link_rdata,
  output logic                         cnt_re,
  output logic                         cnt_we,
  output logic [NW-1:0]                cnt_addr,
  output logic [2*COUNT_BITS-1:0]      cnt_wdata,
  input  wire logic [2*COUNT_BITS-1:0] cnt_rdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LINK,
    S_CNT,
    S_OUT
  } state_t;

  localparam logic [LW-1:0] ALPHA_L = LW'(ALPHABET);
  localparam logic [LW-1:0] CLR_LAST = LW'(LINK_DEPTH - 1);
  localparam logic [LW-1:0] NODES_L = LW'(NODES);
  localparam logic [FW-1:0] NODES_F = FW'(NODES);
  localparam logic [LETTER_W-1:0] ALPHA_5 = LETTER_W'(ALPHABET);

  state_t                 state_r, state_nxt;
  logic [LW-1:0]          clr_r, clr_nxt;
  logic [NW-1:0]          cur_r, cur_nxt;
  logic [FW-1:0]          nfree_r, nfree_nxt;
  logic                   miss_r, miss_nxt;
  logic                   abort_r, abort_nxt;
  logic                   op_r, op_nxt;
  logic                   last_r, last_nxt;
  logic [LW-1:0]          slot_r, slot_nxt;
  logic [NW-1:0]          node_r, node_nxt;
  logic                   bump_pfx_r, bump_pfx_nxt;
  logic                   bump_end_r, bump_end_nxt;
  logic                   fin_r, fin_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [OUT_CNT_W-1:0]   out_wc_r, out_wc_nxt;
  logic [OUT_CNT_W-1:0]   out_pc_r, out_pc_nxt;
  status_t                pend_status_r, pend_status_nxt;
  logic [OUT_CNT_W-1:0]   pend_wc_r, pend_wc_nxt;
  logic [OUT_CNT_W-1:0]   pend_pc_r, pend_pc_nxt;

  logic                   out_free;
  logic                   walk;
  logic                   miss_v;
  logic                   fin_go, fin_miss, fin_abort, fin_bump_end;
  logic [NW-1:0]          fin_node;
  logic                   res_go;
  status_t                res_status;
  logic [OUT_CNT_W-1:0]   res_wc, res_pc;
  logic [NW-1:0]          alloc;
  logic                   nz, full;
  logic [COUNT_BITS-1:0]  pfx_old, end_old, pfx_new, end_new;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_word_count   = out_wc_r;
  assign out_prefix_count = out_pc_r;

  assign out_free = !out_valid_r || out_ready;
  assign alloc    = nfree_r[NW-1:0];
  assign nz       = (link_rdata != '0);
  assign full     = (nfree_r >= NODES_F);
  assign pfx_old  = cnt_rdata[COUNT_BITS-1:0];
  assign end_old  = cnt_rdata[2*COUNT_BITS-1:COUNT_BITS];
  assign pfx_new  = (bump_pfx_r && pfx_old != '1) ? pfx_old + COUNT_BITS'(1) : pfx_old;
  assign end_new  = (bump_end_r && end_old != '1) ? end_old + COUNT_BITS'(1) : end_old;

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    cur_nxt         = cur_r;
    nfree_nxt       = nfree_r;
    miss_nxt        = miss_r;
    abort_nxt       = abort_r;
    op_nxt          = op_r;
    last_nxt        = last_r;
    slot_nxt        = slot_r;
    node_nxt        = node_r;
    bump_pfx_nxt    = bump_pfx_r;
    bump_end_nxt    = bump_end_r;
    fin_nxt         = fin_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_wc_nxt      = out_wc_r;
    out_pc_nxt      = out_pc_r;
    pend_status_nxt = pend_status_r;
    pend_wc_nxt     = pend_wc_r;
    pend_pc_nxt     = pend_pc_r;
    link_re         = 1'b0;
    link_we         = 1'b0;
    link_addr       = slot_r;
    link_wdata      = '0;
    cnt_re          = 1'b0;
    cnt_we          = 1'b0;
    cnt_addr        = node_r;
    cnt_wdata       = {end_new, pfx_new};
    walk            = 1'b0;
    miss_v          = miss_r;
    fin_go          = 1'b0;
    fin_miss        = 1'b0;
    fin_abort       = 1'b0;
    fin_bump_end    = 1'b0;
    fin_node        = cur_r;
    res_go          = 1'b0;
    res_status      = STAT_OK;
    res_wc          = '0;
    res_pc          = '0;

    unique case (state_r)
      S_CLEAR: begin
        link_we   = 1'b1;
        link_addr = clr_r;
        cnt_we    = (clr_r < NODES_L);
        cnt_addr  = clr_r[NW-1:0];
        cnt_wdata = '0;
        clr_nxt   = clr_r + LW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          last_nxt = in_last;
          walk = !in_empty_word && !abort_r && !miss_r && (in_letter < ALPHA_5);
          if (walk) begin
            slot_nxt  = LW'(cur_r) * ALPHA_L + LW'(in_letter);
            link_addr = slot_nxt;
            link_re   = 1'b1;
            state_nxt = S_LINK;
          end else begin
            miss_v = miss_r || (!in_empty_word && !abort_r && in_op == OP_FIND);
            miss_nxt = miss_v;
            if (in_empty_word || in_last) begin
              fin_go       = 1'b1;
              fin_miss     = miss_v;
              fin_abort    = abort_r;
              fin_node     = cur_r;
              fin_bump_end = (in_op == OP_INSERT);
            end
          end
        end
      end
      S_LINK: begin
        state_nxt = S_IDLE;
        if (op_r == OP_FIND) begin
          if (nz) begin
            cur_nxt = link_rdata;
          end else begin
            miss_nxt = 1'b1;
          end
          if (last_r) begin
            fin_go   = 1'b1;
            fin_miss = !nz;
            fin_node = link_rdata;
          end
        end else if (!nz && full) begin
          abort_nxt = 1'b1;
          if (last_r) begin
            fin_go    = 1'b1;
            fin_abort = 1'b1;
          end
        end else begin
          if (nz) begin
            node_nxt = link_rdata;
          end else begin
            node_nxt   = alloc;
            link_we    = 1'b1;
            link_wdata = alloc;
            nfree_nxt  = nfree_r + FW'(1);
          end
          cur_nxt      = node_nxt;
          cnt_re       = 1'b1;
          cnt_addr     = node_nxt;
          bump_pfx_nxt = 1'b1;
          bump_end_nxt = last_r;
          fin_nxt      = last_r;
          state_nxt    = S_CNT;
        end
      end
      S_CNT: begin
        cnt_we    = bump_pfx_r || bump_end_r;
        state_nxt = S_IDLE;
        if (fin_r) begin
          res_go = 1'b1;
          res_wc = OUT_CNT_W'(end_new);
          res_pc = OUT_CNT_W'(pfx_new);
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_wc_nxt     = pend_wc_r;
          out_pc_nxt     = pend_pc_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin_go) begin
      if (fin_abort) begin
        res_go     = 1'b1;
        res_status = STAT_FULL;
      end else if (fin_miss) begin
        res_go     = 1'b1;
        res_status = STAT_MISS;
      end else begin
        cnt_re       = 1'b1;
        cnt_addr     = fin_node;
        node_nxt     = fin_node;
        bump_pfx_nxt = 1'b0;
        bump_end_nxt = fin_bump_end;
        fin_nxt      = 1'b1;
        state_nxt    = S_CNT;
      end
    end

    if (res_go) begin
      cur_nxt   = '0;
      miss_nxt  = 1'b0;
      abort_nxt = 1'b0;
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status;
        out_wc_nxt     = res_wc;
        out_pc_nxt     = res_pc;
        state_nxt      = S_IDLE;
      end else begin
        pend_status_nxt = res_status;
        pend_wc_nxt     = res_wc;
        pend_pc_nxt     = res_pc;
        state_nxt       = S_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      nfree_r     <= FW'(1);
      miss_r      <= 1'b0;
      abort_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      nfree_r     <= nfree_nxt;
      miss_r      <= miss_nxt;
      abort_r     <= abort_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    last_r        <= last_nxt;
    slot_r        <= slot_nxt;
    node_r        <= node_nxt;
    bump_pfx_r    <= bump_pfx_nxt;
    bump_end_r    <= bump_end_nxt;
    fin_r         <= fin_nxt;
    out_status_r  <= out_status_nxt;
    out_wc_r      <= out_wc_nxt;
    out_pc_r      <= out_pc_nxt;
    pend_status_r <= pend_status_nxt;
    pend_wc_r     <= pend_wc_nxt;
    pend_pc_r     <= pend_pc_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/trie_word_insert_and_count_core.sv
// Top level of the trie word insert and count core.
// Keeps a trie of up to NODES nodes with ALPHABET child links each; one letter per
// request, op selects insert or find, and one result is returned per word (status,
// end count, prefix count). After reset the core clears the link and count memories with
// in_ready low. An insert letter that walks is accepted, then its link is read (and a new
// node allocated when the link is empty), then its counts get a read-modify-write; on the
// last letter the end count bump rides on the same read-modify-write. A find letter that
// walks reads its link, and its counts too when it ends a word on a hit. A letter that
// does not walk (empty word, out-of-range letter, halted walk) is taken in the idle state,
// and its counts are read when it ends a word whose walk was not halted. These steps
// follow from the registered read data of the single-port link and count RAMs. A result
// waits in the output register while later letters are accepted; a further result that
// finds it still occupied holds in_ready low until the waiting one is taken.
`default_nettype none
module trie_word_insert_and_count_core
  import twic_pkg::*;
#(
  parameter int NODES      = TWIC_NODES,
  parameter int ALPHABET   = TWIC_ALPHABET,
  parameter int COUNT_BITS = TWIC_COUNT_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic [LETTER_W-1:0]  in_letter,
  input  wire logic                 in_last,
  input  wire logic                 in_empty_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_status,
  output logic [OUT_CNT_W-1:0]      out_word_count,
  output logic [OUT_CNT_W-1:0]      out_prefix_count
);

  localparam int NW = $clog2(NODES);
  localparam int LINK_DEPTH = NODES * ALPHABET;
  localparam int LW = $clog2(LINK_DEPTH);

  logic                    link_re, link_we;
  logic [LW-1:0]           link_addr;
  logic [NW-1:0]           link_wdata, link_rdata;
  logic                    cnt_re, cnt_we;
  logic [NW-1:0]           cnt_addr;
  logic [2*COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

  twic_ctrl #(
    .NODES      (NODES),
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_letter        (in_letter),
    .in_last          (in_last),
    .in_empty_word    (in_empty_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_word_count   (out_word_count),
    .out_prefix_count (out_prefix_count),
    .link_re          (link_re),
    .link_we          (link_we),
    .link_addr        (link_addr),
    .link_wdata       (link_wdata),
    .link_rdata       (link_rdata),
    .cnt_re           (cnt_re),
    .cnt_we           (cnt_we),
    .cnt_addr         (cnt_addr),
    .cnt_wdata        (cnt_wdata),
    .cnt_rdata        (cnt_rdata)
  );

  twic_ram #(
    .DEPTH (LINK_DEPTH),
    .WIDTH (NW)
  ) u_link_ram (
    .clk   (clk),
    .re    (link_re),
    .we    (link_we),
    .addr  (link_addr),
    .wdata (link_wdata),
    .rdata (link_rdata)
  );

  twic_ram #(
    .DEPTH (NODES),
    .WIDTH (2 * COUNT_BITS)
  ) u_count_ram (
    .clk   (clk),
    .re    (cnt_re),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the trie word insert and count core: directed table, then random words.
module tb_top;
  import twic_pkg::*;

  localparam int NODES = TWIC_NODES;
  localparam int ALPH = TWIC_ALPHABET;
  localparam int CW = TWIC_COUNT_BITS;
  localparam int RAND_ITEMS = 1000;
  localparam int ABORT_WORDS = 8;

  typedef bit [CW-1:0] count_t;

  typedef struct packed {
    status_t                status;
    logic [OUT_CNT_W-1:0]   word_count;
    logic [OUT_CNT_W-1:0]   prefix_count;
  } word_result_t;

  typedef struct {
    logic         op;
    logic [4:0]   letter;
    logic         last;
    logic         empty;
    bit           typed;
    word_result_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_op;
  logic [LETTER_W-1:0]   in_letter;
  logic                  in_last;
  logic                  in_empty_word;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_status;
  logic [OUT_CNT_W-1:0]  out_word_count;
  logic [OUT_CNT_W-1:0]  out_prefix_count;

  trie_word_insert_and_count_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_letter        (in_letter),
    .in_last          (in_last),
    .in_empty_word    (in_empty_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_word_count   (out_word_count),
    .out_prefix_count (out_prefix_count)
  );

  always #4 clk = ~clk;

  // trie shadow
  int unsigned  child_of [NODES*ALPH];
  count_t       pfx_cnt [NODES];
  count_t       end_cnt [NODES];
  int unsigned  walk_node = 0;
  int unsigned  free_node = 1;
  bit           walk_missed = 1'b0;
  bit           walk_aborted = 1'b0;
  int           aborted_words = 0;

  word_result_t expected_words[$];
  stim_row_t    directed_rows[$];
  int           mismatches = 0;
  bit           calm = 1'b0;
  int           stall_left = 0;

  function automatic count_t sat_bump(count_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic trie_step(input logic op, input logic [4:0] letter, input logic last,
                           input logic empty, output bit ends, output word_result_t r);
    int unsigned slot;
    int unsigned nxt;
    bit          is_find;
    is_find = (op == OP_FIND);
    r = '0;
    r.status = STAT_OK;
    if (!empty && !walk_aborted && !walk_missed) begin
      if (int'(letter) >= ALPH) begin
        if (is_find) walk_missed = 1'b1;
      end else begin
        slot = walk_node * ALPH + letter;
        nxt = child_of[slot];
        if (is_find) begin
          if (nxt == 0) walk_missed = 1'b1;
          else walk_node = nxt;
        end else begin
          if (nxt == 0) begin
            if (free_node >= NODES) begin
              walk_aborted = 1'b1;
            end else begin
              nxt = free_node;
              child_of[slot] = nxt;
              free_node++;
            end
          end
          if (!walk_aborted) begin
            walk_node = nxt;
            pfx_cnt[nxt] = sat_bump(pfx_cnt[nxt]);
          end
        end
      end
    end
    ends = empty || last;
    if (ends) begin
      if (walk_aborted) begin
        r.status = STAT_FULL;
        aborted_words++;
      end else if (walk_missed) begin
        r.status = STAT_MISS;
      end else begin
        if (!is_find) end_cnt[walk_node] = sat_bump(end_cnt[walk_node]);
        r.word_count = end_cnt[walk_node][OUT_CNT_W-1:0];
        r.prefix_count = pfx_cnt[walk_node][OUT_CNT_W-1:0];
      end
      walk_node = 0;
      walk_missed = 1'b0;
      walk_aborted = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void add_row(input logic op, input logic [4:0] letter, input logic last,
                                  input logic empty, input bit typed, input status_t st,
                                  input int unsigned wc, input int unsigned pc);
    stim_row_t row;
    row.op = op;
    row.letter = letter;
    row.last = last;
    row.empty = empty;
    row.typed = typed;
    row.want.status = st;
    row.want.word_count = wc;
    row.want.prefix_count = pc;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [4:0] pick_letter(input int span);
    if ($urandom_range(0, 19) == 0) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(0, span - 1));
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_letter(input logic op, input logic [4:0] letter, input logic last,
                             input logic empty, input bit typed, input word_result_t want);
    bit           ends;
    word_result_t got;
    int           gap;
    in_op <= op;
    in_letter <= letter;
    in_last <= last;
    in_empty_word <= empty;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    trie_step(op, letter, last, empty, ends, got);
    if (ends) expected_words.push_back(typed ? want : got);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_words
    word_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("result with no word pending");
      end else begin
        want = expected_words.pop_front();
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_word_count !== want.word_count)
          flag_mismatch($sformatf("word_count %0d, want %0d", out_word_count,
                                  want.word_count));
        if (out_prefix_count !== want.prefix_count)
          flag_mismatch($sformatf("prefix_count %0d, want %0d", out_prefix_count,
                                  want.prefix_count));
      end
    end
  end

  initial begin : stimulus
    int   len;
    int   kind;
    int   span;
    int   rand_sent;
    bit   mixed;
    bit   close_empty;
    bit   long_word;
    logic word_op;
    logic op;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_INSERT;
    in_letter = '0;
    in_last = 1'b0;
    in_empty_word = 1'b0;
    rand_sent = 0;

    //       op         letter  last  empty typed status     wc pc
    add_row(OP_FIND,   5'd0,   1'b1, 1'b0, 1'b1, STAT_MISS, 0, 0);
    add_row(OP_INSERT, 5'd31,  1'b0, 1'b1, 1'b1, STAT_OK,   1, 0);
    add_row(OP_FIND,   5'd0,   1'b1, 1'b1, 1'b1, STAT_OK,   1, 0);
    add_row(OP_INSERT, 5'd0,   1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_INSERT, 5'd25,  1'b1, 1'b0, 1'b1, STAT_OK,   1, 1);
    add_row(OP_FIND,   5'd0,   1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_FIND,   5'd25,  1'b1, 1'b0, 1'b1, STAT_OK,   1, 1);
    add_row(OP_INSERT, 5'd31,  1'b1, 1'b0, 1'b1, STAT_OK,   2, 0);
    add_row(OP_FIND,   5'd26,  1'b1, 1'b0, 1'b1, STAT_MISS, 0, 0);
    add_row(OP_FIND,   5'd16,  1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_FIND,   5'd0,   1'b1, 1'b0, 1'b1, STAT_MISS, 0, 0);
    add_row(OP_INSERT, 5'd0,   1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_FIND,   5'd1,   1'b1, 1'b0, 1'b1, STAT_MISS, 0, 0);
    add_row(OP_FIND,   5'd0,   1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_INSERT, 5'd2,   1'b1, 1'b0, 1'b1, STAT_OK,   1, 1);
    add_row(OP_INSERT, 5'd0,   1'b1, 1'b0, 1'b1, STAT_OK,   1, 3);
    add_row(OP_INSERT, 5'd1,   1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_FIND,   5'd7,   1'b0, 1'b1, 1'b1, STAT_OK,   0, 1);
    add_row(OP_INSERT, 5'd0,   1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_INSERT, 5'd25,  1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_INSERT, 5'd24,  1'b1, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_FIND,   5'd0,   1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_FIND,   5'd25,  1'b0, 1'b0, 1'b0, STAT_OK,   0, 0);
    add_row(OP_FIND,   5'd24,  1'b1, 1'b0, 1'b0, STAT_OK,   0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_letter(directed_rows[i].op, directed_rows[i].letter, directed_rows[i].last,
                  directed_rows[i].empty, directed_rows[i].typed, directed_rows[i].want);

    // hold off until the core has drained every pending word
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_words.size() != 0);

    while (rand_sent < RAND_ITEMS || aborted_words < ABORT_WORDS) begin
      kind = $urandom_range(0, 99);
      if (free_node < NODES && rand_sent > 20 && kind < 90) begin
        // long fresh insert words to exhaust the node pool
        long_word = 1'b1;
        close_empty = 1'b0;
        len = $urandom_range(16, 24);
        word_op = OP_INSERT;
        span = ALPH;
        mixed = 1'b0;
      end else begin
        long_word = 1'b0;
        close_empty = ($urandom_range(0, 11) == 0);
        len = $urandom_range(close_empty ? 0 : 1, 6);
        word_op = 1'($urandom_range(0, 1));
        span = ($urandom_range(0, 9) < 6) ? 3 : ALPH;
        mixed = ($urandom_range(0, 9) == 0);
        if (free_node >= NODES && $urandom_range(0, 1) == 1) begin
          word_op = OP_INSERT;
          span = ALPH;
          len = $urandom_range(3, 8);
        end
      end
      for (int i = 0; i < len; i++) begin
        op = mixed ? 1'($urandom_range(0, 1)) : word_op;
        send_letter(op, long_word ? 5'($urandom_range(0, ALPH - 1)) : pick_letter(span),
                    (i == len - 1) && !close_empty, 1'b0, 1'b0, '0);
        rand_sent++;
      end
      if (close_empty) begin
        send_letter(word_op, 5'($urandom), 1'($urandom), 1'b1, 1'b0, '0);
        rand_sent++;
      end
      if (rand_sent >= RAND_ITEMS - 150) calm = 1'b1;
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
sv/twic_pkg.sv
sv/twic_ram.sv
sv/twic_ctrl.sv
sv/trie_word_insert_and_count_core.sv
bench/tb_top.sv
